FILE: rtl/nearest_center_assigner_core_defines.svh
// Assertion macros shared by several of the RTL files
`ifndef NEAREST_CENTER_ASSIGNER_CORE_DEFINES_SVH
`define NEAREST_CENTER_ASSIGNER_CORE_DEFINES_SVH

`define NCAC_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

`define NCAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ncac_pkg.sv
`default_nettype none

package ncac_pkg;

    localparam int COORD_W          = 16;
    localparam int SQ_W             = 32;
    localparam int ACC_W            = 40;
    localparam int CNT_W            = 16;
    localparam int CFG_W            = 7;
    localparam int DEF_NUM_CENTERS  = 2;
    localparam int DEF_MAX_DIMS     = 64;
    localparam int FIFO_DEPTH       = 8;
    localparam int FIFO_CW          = $clog2(FIFO_DEPTH + 1);

    localparam logic [CFG_W-1:0] NUM_DIMS_RESET = CFG_W'(2);
    localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic sos;
    } t_ctl;

endpackage

`default_nettype wire

FILE: rtl/ncac_if.sv
`default_nettype none

interface ncac_in_if;
    import ncac_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coordinate;
    logic                      start_of_set;

    modport source (output valid, output coordinate, output start_of_set, input ready);
    modport sink (input valid, input coordinate, input start_of_set, output ready);
endinterface

interface ncac_out_if #(
    parameter int IDX_W = 1
);
    import ncac_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] center_index;
    logic [CNT_W-1:0] slot;
    logic             count_saturated;

    modport source (
        output valid, output center_index, output slot, output count_saturated,
        input ready
    );
    modport sink (
        input valid, input center_index, input slot, input count_saturated,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/nearest_center_assigner_core.sv
// Channel   Dir  Payload                                  Transaction
// i_in      in   coordinate, start_of_set                 one coordinate of a point
// o_out     out  center_index, slot, count_saturated      one finished point
// i_cfg     in   i_cfg_wdata (num_dims)                   register write on i_cfg_we
//
// Takes one coordinate per cycle while ready: one center-bank read and squaring per center.
// A result passes the front, squaring and accumulate registers, then enters the output buffer.
// Reset is synchronous; it clears counters, seeding and member counts, no clearing pass.
// i_in.ready drops when buffered plus in-flight results would exceed 8 entries.
`default_nettype none

module nearest_center_assigner_core #(
    parameter int NUM_CENTERS = ncac_pkg::DEF_NUM_CENTERS,
    parameter int MAX_DIMS    = ncac_pkg::DEF_MAX_DIMS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    ncac_in_if.sink                          i_in,
    ncac_out_if.source                       o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [ncac_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import ncac_pkg::*;

    localparam int IDX_W = $clog2(NUM_CENTERS);
    localparam int OW    = IDX_W + CNT_W + 1;
    localparam int SUM_W = FIFO_CW + 1;

    logic [CFG_W-1:0]                   r_num_dims;
    logic                               accept;
    t_ctl                               ctl_p1;
    t_ctl                               ctl_sq;
    t_ctl                               ctl_fin;
    logic signed [COORD_W-1:0]          coord_p1;
    logic [NUM_CENTERS-1:0][COORD_W-1:0] center_p1;
    logic [NUM_CENTERS-1:0]             vmask_p1;
    logic [NUM_CENTERS-1:0][ACC_W-1:0]  fin;
    logic [NUM_CENTERS-1:0]             vmask_fin;
    logic                               push;
    logic [IDX_W-1:0]                   sel_idx;
    logic [CNT_W-1:0]                   sel_slot;
    logic                               sel_sat;
    logic [OW-1:0]                      out_data;
    logic [FIFO_CW-1:0]                 fifo_cnt;
    logic [SUM_W-1:0]                   pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= NUM_DIMS_RESET;
        end else if (i_cfg_we) begin
            r_num_dims <= i_cfg_wdata;
        end
    end

    assign pending = SUM_W'(fifo_cnt)
                   + SUM_W'(ctl_p1.vld && ctl_p1.last)
                   + SUM_W'(ctl_sq.vld && ctl_sq.last)
                   + SUM_W'(ctl_fin.vld);
    assign i_in.ready = (pending < SUM_W'(FIFO_DEPTH));
    assign accept     = i_in.valid && i_in.ready;

    ncac_front #(
        .NUM_CENTERS (NUM_CENTERS),
        .MAX_DIMS    (MAX_DIMS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_num_dims (r_num_dims),
        .i_accept   (accept),
        .i_coord    (i_in.coordinate),
        .i_sos      (i_in.start_of_set),
        .o_ctl      (ctl_p1),
        .o_coord    (coord_p1),
        .o_center   (center_p1),
        .o_vmask    (vmask_p1)
    );

    ncac_dist #(
        .NUM_CENTERS (NUM_CENTERS)
    ) u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl_p1),
        .i_coord   (coord_p1),
        .i_center  (center_p1),
        .i_vmask   (vmask_p1),
        .o_ctl_sq  (ctl_sq),
        .o_ctl_fin (ctl_fin),
        .o_fin     (fin),
        .o_vmask   (vmask_fin)
    );

    ncac_select #(
        .NUM_CENTERS (NUM_CENTERS),
        .IDX_W       (IDX_W)
    ) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_fin),
        .i_fin   (fin),
        .i_vmask (vmask_fin),
        .o_push  (push),
        .o_idx   (sel_idx),
        .o_slot  (sel_slot),
        .o_sat   (sel_sat)
    );

    ncac_out_fifo #(
        .W (OW)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({sel_idx, sel_slot, sel_sat}),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_data  (out_data),
        .o_count (fifo_cnt)
    );

    assign o_out.center_index    = out_data[OW-1 -: IDX_W];
    assign o_out.slot            = out_data[CNT_W:1];
    assign o_out.count_saturated = out_data[0];

endmodule

`default_nettype wire

FILE: rtl/ncac_front.sv
`default_nettype none

`include "nearest_center_assigner_core_defines.svh"

module ncac_front #(
    parameter int NUM_CENTERS = ncac_pkg::DEF_NUM_CENTERS,
    parameter int MAX_DIMS    = ncac_pkg::DEF_MAX_DIMS
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic [ncac_pkg::CFG_W-1:0]                    i_num_dims,
    input  wire logic                                          i_accept,
    input  wire logic signed [ncac_pkg::COORD_W-1:0]           i_coord,
    input  wire logic                                          i_sos,
    output ncac_pkg::t_ctl                                     o_ctl,
    output logic signed [ncac_pkg::COORD_W-1:0]                o_coord,
    output logic [NUM_CENTERS-1:0][ncac_pkg::COORD_W-1:0]      o_center,
    output logic [NUM_CENTERS-1:0]                             o_vmask
);
    import ncac_pkg::*;

    localparam int DIM_BITS = $clog2(MAX_DIMS + 1);
    localparam int EW       = (CFG_W > DIM_BITS) ? CFG_W : DIM_BITS;
    localparam int AW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SW       = $clog2(NUM_CENTERS + 1);

    logic [EW-1:0]          nd;
    logic [EW-1:0]          dims;
    logic [EW-1:0]          dlast;
    logic [EW-1:0]          cnt_ext;
    logic [AW-1:0]          cnt_eff;
    logic [AW-1:0]          d;
    logic                   last;
    logic [SW-1:0]          seed_eff;
    logic                   seeding;

    logic [AW-1:0]          r_dim_cnt;
    logic [SW-1:0]          r_seeded;
    logic                   r_sos_hold;
    t_ctl                   r_ctl;
    logic signed [COORD_W-1:0] r_coord;
    logic [NUM_CENTERS-1:0] r_vmask;
    logic [NUM_CENTERS-1:0] n_vmask;

    always_comb begin
        nd       = EW'(i_num_dims);
        if (nd == '0) begin
            dims = EW'(1);
        end else if (nd > EW'(MAX_DIMS)) begin
            dims = EW'(MAX_DIMS);
        end else begin
            dims = nd;
        end
        dlast    = dims - EW'(1);
        cnt_eff  = i_sos ? '0 : r_dim_cnt;
        cnt_ext  = EW'(cnt_eff);
        last     = (cnt_ext >= dlast);
        d        = last ? dlast[AW-1:0] : cnt_eff;
        seed_eff = i_sos ? '0 : r_seeded;
        seeding  = (seed_eff < SW'(NUM_CENTERS));
        for (int c = 0; c < NUM_CENTERS; c++) begin
            n_vmask[c] = !seeding || (SW'(c) <= seed_eff);
        end
    end

    // hold a start of set until the point that it opens finishes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_cnt  <= '0;
            r_seeded   <= '0;
            r_sos_hold <= 1'b0;
            r_ctl      <= '0;
        end else begin
            r_ctl.vld   <= i_accept;
            r_ctl.first <= (cnt_eff == '0);
            r_ctl.last  <= last;
            r_ctl.sos   <= i_sos || r_sos_hold;
            if (i_accept) begin
                r_dim_cnt  <= last ? '0 : d + AW'(1);
                r_seeded   <= (last && seeding) ? seed_eff + SW'(1) : seed_eff;
                r_sos_hold <= last ? 1'b0 : (i_sos || r_sos_hold);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_coord <= i_coord;
            r_vmask <= n_vmask;
        end
    end

    for (genvar c = 0; c < NUM_CENTERS; c++) begin : g_bank
        logic [COORD_W-1:0] r_mem [MAX_DIMS];
        logic [COORD_W-1:0] r_rd;
        logic               we;

        assign we = i_accept && seeding && (seed_eff == SW'(c));

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[d] <= i_coord;
            end
            if (i_accept) begin
                r_rd <= we ? i_coord : r_mem[d];
            end
        end

        assign o_center[c] = r_rd;
    end

    assign o_ctl   = r_ctl;
    assign o_coord = r_coord;
    assign o_vmask = r_vmask;

    `NCAC_ASSERT_ALWAYS(a_seed_bound, i_clk, i_rst_n, r_seeded <= SW'(NUM_CENTERS), "seed count past center count")
    `NCAC_ASSERT_NEXT(a_dim_step, i_clk, i_rst_n, i_accept && !last, r_dim_cnt == $past(d) + AW'(1), "dimension counter did not advance")

endmodule

`default_nettype wire

FILE: rtl/ncac_dist.sv
`default_nettype none

module ncac_dist #(
    parameter int NUM_CENTERS = ncac_pkg::DEF_NUM_CENTERS
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire ncac_pkg::t_ctl                                i_ctl,
    input  wire logic signed [ncac_pkg::COORD_W-1:0]           i_coord,
    input  wire logic [NUM_CENTERS-1:0][ncac_pkg::COORD_W-1:0] i_center,
    input  wire logic [NUM_CENTERS-1:0]                        i_vmask,
    output ncac_pkg::t_ctl                                     o_ctl_sq,
    output ncac_pkg::t_ctl                                     o_ctl_fin,
    output logic [NUM_CENTERS-1:0][ncac_pkg::ACC_W-1:0]        o_fin,
    output logic [NUM_CENTERS-1:0]                             o_vmask
);
    import ncac_pkg::*;

    logic signed [COORD_W:0]     diff [NUM_CENTERS];
    logic signed [2*COORD_W+1:0] prod [NUM_CENTERS];
    logic [ACC_W-1:0]            acc_next [NUM_CENTERS];

    t_ctl                   r_ctl_sq;
    logic [SQ_W-1:0]        r_sq [NUM_CENTERS];
    logic [NUM_CENTERS-1:0] r_vm_sq;

    t_ctl                   r_ctl_fin;
    logic [ACC_W-1:0]       r_acc [NUM_CENTERS];
    logic [NUM_CENTERS-1:0][ACC_W-1:0] r_fin;
    logic [NUM_CENTERS-1:0] r_vm_fin;

    always_comb begin
        for (int c = 0; c < NUM_CENTERS; c++) begin
            diff[c] = $signed({i_coord[COORD_W-1], i_coord})
                    - $signed({i_center[c][COORD_W-1], i_center[c]});
            prod[c] = diff[c] * diff[c];
            acc_next[c] = (r_ctl_sq.first ? '0 : r_acc[c]) + ACC_W'(r_sq[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_sq  <= '0;
            r_ctl_fin <= '0;
        end else begin
            r_ctl_sq        <= i_ctl;
            r_ctl_fin.vld   <= r_ctl_sq.vld && r_ctl_sq.last;
            r_ctl_fin.first <= r_ctl_sq.first;
            r_ctl_fin.last  <= r_ctl_sq.last;
            r_ctl_fin.sos   <= r_ctl_sq.sos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_vm_sq <= i_vmask;
            for (int c = 0; c < NUM_CENTERS; c++) begin
                r_sq[c] <= prod[c][SQ_W-1:0];
            end
        end
        if (r_ctl_sq.vld) begin
            for (int c = 0; c < NUM_CENTERS; c++) begin
                r_acc[c] <= acc_next[c];
            end
            if (r_ctl_sq.last) begin
                r_vm_fin <= r_vm_sq;
                for (int c = 0; c < NUM_CENTERS; c++) begin
                    r_fin[c] <= acc_next[c];
                end
            end
        end
    end

    assign o_ctl_sq  = r_ctl_sq;
    assign o_ctl_fin = r_ctl_fin;
    assign o_fin     = r_fin;
    assign o_vmask   = r_vm_fin;

endmodule

`default_nettype wire

FILE: rtl/ncac_select.sv
`default_nettype none

`include "nearest_center_assigner_core_defines.svh"

module ncac_select #(
    parameter int NUM_CENTERS = ncac_pkg::DEF_NUM_CENTERS,
    parameter int IDX_W       = $clog2(NUM_CENTERS)
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire ncac_pkg::t_ctl                              i_ctl,
    input  wire logic [NUM_CENTERS-1:0][ncac_pkg::ACC_W-1:0] i_fin,
    input  wire logic [NUM_CENTERS-1:0]                      i_vmask,
    output logic                                             o_push,
    output logic [IDX_W-1:0]                                 o_idx,
    output logic [ncac_pkg::CNT_W-1:0]                       o_slot,
    output logic                                             o_sat
);
    import ncac_pkg::*;

    localparam int P = 1 << IDX_W;

    logic [ACC_W:0]   key [P];
    logic [IDX_W-1:0] kid [P];
    logic [IDX_W-1:0] best;
    logic [CNT_W-1:0] cnt_sel;
    logic             sat;
    logic [CNT_W-1:0] n_cnt [NUM_CENTERS];
    logic [CNT_W-1:0] r_cnt [NUM_CENTERS];

    always_comb begin
        for (int j = 0; j < P; j++) begin
            if (j < NUM_CENTERS) begin
                key[j] = {~i_vmask[j], i_fin[j]};
            end else begin
                key[j] = '1;
            end
            kid[j] = IDX_W'(j);
        end
        for (int lvl = 0; lvl < IDX_W; lvl++) begin
            for (int j = 0; j < (P >> (lvl + 1)); j++) begin
                if (key[2*j+1] <= key[2*j]) begin
                    key[j] = key[2*j+1];
                    kid[j] = kid[2*j+1];
                end else begin
                    key[j] = key[2*j];
                    kid[j] = kid[2*j];
                end
            end
        end
        best    = kid[0];
        cnt_sel = i_ctl.sos ? '0 : r_cnt[best];
        sat     = (cnt_sel == CNT_MAX);
        for (int c = 0; c < NUM_CENTERS; c++) begin
            n_cnt[c] = i_ctl.sos ? '0 : r_cnt[c];
            if ((IDX_W'(c) == best) && !sat) begin
                n_cnt[c] = cnt_sel + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CENTERS; c++) begin
                r_cnt[c] <= '0;
            end
        end else if (i_ctl.vld) begin
            for (int c = 0; c < NUM_CENTERS; c++) begin
                r_cnt[c] <= n_cnt[c];
            end
        end
    end

    assign o_push = i_ctl.vld;
    assign o_idx  = best;
    assign o_slot = cnt_sel;
    assign o_sat  = sat;

    `NCAC_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, i_ctl.vld && !sat, r_cnt[$past(best)] == $past(cnt_sel) + CNT_W'(1), "member count did not advance")

endmodule

`default_nettype wire

FILE: rtl/ncac_out_fifo.sv
`default_nettype none

`include "nearest_center_assigner_core_defines.svh"

module ncac_out_fifo #(
    parameter int W = 18
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [W-1:0]                  i_data,
    input  wire logic                          i_ready,
    output logic                               o_valid,
    output logic [W-1:0]                       o_data,
    output logic [ncac_pkg::FIFO_CW-1:0]       o_count
);
    import ncac_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    logic [W-1:0]       r_buf [FIFO_DEPTH];
    logic [PW-1:0]      r_wr;
    logic [PW-1:0]      r_rd;
    logic [FIFO_CW-1:0] r_cnt;
    logic               pop;
    logic               full;

    assign pop  = o_valid && i_ready;
    assign full = (r_cnt == FIFO_CW'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + PW'(1);
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + FIFO_CW'(1);
                2'b01:   r_cnt <= r_cnt - FIFO_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rd];
    assign o_count = r_cnt;

    `NCAC_ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && full && !pop), "result buffer overflow")

endmodule

`default_nettype wire

FILE: test/tb_nearest_center_assigner_core.sv
`timescale 1ns / 1ps

module tb_nearest_center_assigner_core;
    import ncac_pkg::*;

    localparam int NCENT        = DEF_NUM_CENTERS;
    localparam int MAXD         = DEF_MAX_DIMS;
    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic             center_index;
        logic [CNT_W-1:0] slot;
        logic             count_saturated;
    } assignment_t;

    typedef enum int {PICK_ANY, PICK_EDGE, PICK_BASE, PICK_NEAR} pick_mode_t;

    class assignment_tracker;
        logic signed [COORD_W-1:0] center_coords [NCENT][MAXD];
        logic [ACC_W-1:0]          dist_sum [NCENT];
        logic [CNT_W-1:0]          members [NCENT];
        int unsigned               dim_pos;
        int unsigned               seeded;
        logic [CFG_W-1:0]          num_dims;
        assignment_t               pending [$];
        int                        mismatches;

        function new();
            for (int c = 0; c < NCENT; c++) begin
                for (int d = 0; d < MAXD; d++) begin
                    center_coords[c][d] = '0;
                end
                dist_sum[c] = '0;
                members[c]  = '0;
            end
            dim_pos    = 0;
            seeded     = 0;
            num_dims   = NUM_DIMS_RESET;
            mismatches = 0;
        endfunction

        function void note_coordinate(logic signed [COORD_W-1:0] coord, logic sos);
            int unsigned dims;
            int unsigned d;
            int unsigned nvalid;
            int unsigned best_c;
            int          c;
            longint      diff;
            longint unsigned best;
            logic [ACC_W-1:0] sq;
            logic [CNT_W-1:0] cnt;
            bit          seeding;
            assignment_t a;
            if (sos) begin
                for (c = 0; c < NCENT; c++) begin
                    members[c]  = '0;
                    dist_sum[c] = '0;
                end
                seeded  = 0;
                dim_pos = 0;
            end
            dims = (num_dims == 0) ? 1 : ((num_dims > MAXD) ? MAXD : num_dims);
            d = (dim_pos >= dims) ? dims - 1 : dim_pos;
            seeding = (seeded < NCENT);
            if (seeding) begin
                center_coords[seeded][d] = coord;
            end
            nvalid = seeding ? seeded + 1 : NCENT;
            for (c = 0; c < nvalid; c++) begin
                diff = longint'(coord) - longint'(center_coords[c][d]);
                sq = diff * diff;
                dist_sum[c] = dist_sum[c] + sq;
            end
            if (d + 1 < dims) begin
                dim_pos = d + 1;
                return;
            end
            best   = '1;
            best_c = 0;
            for (c = 0; c < nvalid; c++) begin
                if (best >= dist_sum[c]) begin
                    best   = dist_sum[c];
                    best_c = c;
                end
            end
            for (c = 0; c < NCENT; c++) begin
                dist_sum[c] = '0;
            end
            dim_pos = 0;
            if (seeding) begin
                seeded++;
            end
            cnt = members[best_c];
            a.center_index    = best_c[0];
            a.slot            = cnt;
            a.count_saturated = (cnt == CNT_MAX);
            if (!a.count_saturated) begin
                members[best_c] = cnt + 1'b1;
            end
            pending.push_back(a);
        endfunction

        function void report(string what, longint unsigned want, longint unsigned got);
            mismatches++;
            if (mismatches <= 100) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            end
        endfunction

        function void check_assignment(logic idx, logic [CNT_W-1:0] slot, logic sat);
            assignment_t a;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 100) begin
                    $display("%0t: transaction with none expected, actual index %0d slot %0d sat %0d",
                             $time, idx, slot, sat);
                end
                return;
            end
            a = pending.pop_front();
            if (a.center_index !== idx) begin
                report("center_index", a.center_index, idx);
            end
            if (a.slot !== slot) begin
                report("slot", a.slot, slot);
            end
            if (a.count_saturated !== sat) begin
                report("count_saturated", a.count_saturated, sat);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    ncac_in_if             in_ch ();
    ncac_out_if #(.IDX_W(1)) out_ch ();

    nearest_center_assigner_core #(
        .NUM_CENTERS(NCENT),
        .MAX_DIMS   (MAXD)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    assignment_tracker tracker;
    bit                idle_on;
    int                sent_items;
    int                cur_eff;
    int                cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_nearest_center_assigner_core: done, errors");
        $finish;
    end

    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            tracker.check_assignment(out_ch.center_index, out_ch.slot, out_ch.count_saturated);
            @(negedge i_clk);
        end
    end

    function automatic int eff_of(int v);
        eff_of = (v == 0) ? 1 : ((v > MAXD) ? MAXD : v);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(pick_mode_t mode,
                                                            logic signed [COORD_W-1:0] base);
        logic [COORD_W-1:0] noise;
        noise = COORD_W'($urandom_range(0, 30));
        case (mode)
            PICK_ANY: pick_coord = COORD_W'($urandom);
            PICK_EDGE: begin
                case ($urandom_range(0, 3))
                    0:       pick_coord = 16'sh8000;
                    1:       pick_coord = 16'sh7FFF;
                    2:       pick_coord = 16'sh0000;
                    default: pick_coord = 16'shFFFF;
                endcase
            end
            PICK_BASE: pick_coord = base;
            default:   pick_coord = base + $signed(noise) - 16'sd15;
        endcase
    endfunction

    task automatic send_coord(input logic signed [COORD_W-1:0] c, input logic sos);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.coordinate   = c;
        in_ch.start_of_set = sos;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.note_coordinate(c, sos);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_ch.valid = 1'b0;
        while (tracker.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_dims(input logic [CFG_W-1:0] v);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge i_clk);
        cfg_we = 1'b0;
        tracker.num_dims = v;
        cur_eff = eff_of(int'(v));
    endtask

    task automatic run_phase();
        int r;
        int dims_val;
        int eff;
        int npoints;
        int cut;
        bit sos_pending;
        pick_mode_t mode;
        logic signed [COORD_W-1:0] base [MAXD];
        r = $urandom_range(0, 99);
        if (r < 5) dims_val = 0;
        else if (r < 9) dims_val = $urandom_range(MAXD + 1, 127);
        else if (r < 12) dims_val = MAXD;
        else if (r < 16) dims_val = $urandom_range(9, 40);
        else dims_val = $urandom_range(1, 8);
        eff = eff_of(dims_val);
        sos_pending = (eff > cur_eff) || ($urandom_range(0, 3) == 0);
        write_dims(dims_val[CFG_W-1:0]);
        idle_on = ($urandom_range(0, 3) != 0);
        npoints = (eff > 16) ? $urandom_range(3, 4) : $urandom_range(3, 30);
        for (int d = 0; d < MAXD; d++) begin
            base[d] = COORD_W'($urandom);
        end
        for (int p = 0; p < npoints; p++) begin
            r = $urandom_range(0, 9);
            mode = (r < 3) ? PICK_ANY : (r < 4) ? PICK_EDGE : (r < 5) ? PICK_BASE : PICK_NEAR;
            for (int d = 0; d < eff; d++) begin
                send_coord(pick_coord(mode, base[d]), sos_pending || ($urandom_range(0, 49) == 0));
                sos_pending = 1'b0;
            end
        end
        if (eff > 1 && $urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, eff - 1);
            for (int d = 0; d < cut; d++) begin
                send_coord(pick_coord(PICK_ANY, base[d]), 1'b0);
            end
        end
        settle();
    endtask

    initial begin
        int first_random;
        tracker            = new();
        idle_on            = 1'b1;
        sent_items         = 0;
        cur_eff            = eff_of(int'(NUM_DIMS_RESET));
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.coordinate   = '0;
        in_ch.start_of_set = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // seeds at opposite corners, then a repeat of the first seed and exact ties between them
        send_coord(16'sh7FFF, 1'b1);
        send_coord(16'sh8000, 1'b0);
        send_coord(16'sh8000, 1'b0);
        send_coord(16'sh7FFF, 1'b0);
        send_coord(16'sh7FFF, 1'b0);
        send_coord(16'sh8000, 1'b0);
        send_coord(16'sh0000, 1'b0);
        send_coord(16'sh0000, 1'b0);
        send_coord(16'shFFFF, 1'b0);
        send_coord(16'shFFFF, 1'b0);
        settle();

        // zero count acts as one; duplicate centers tie
        write_dims(CFG_W'(0));
        send_coord(16'sd5, 1'b1);
        send_coord(16'sd5, 1'b0);
        send_coord(16'sd5, 1'b0);
        send_coord(16'sh8000, 1'b0);
        settle();

        // lower the count in the middle of a seed point
        write_dims(CFG_W'(3));
        send_coord(16'sd100, 1'b1);
        send_coord(-16'sd200, 1'b0);
        settle();
        write_dims(CFG_W'(2));
        send_coord(16'sd300, 1'b0);
        send_coord(16'sd7, 1'b0);
        send_coord(16'sd8, 1'b0);
        settle();

        first_random = sent_items;
        while (sent_items - first_random < RANDOM_ITEMS) begin
            run_phase();
        end
        settle();

        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("tb_nearest_center_assigner_core: done, clean");
        end else begin
            $display("tb_nearest_center_assigner_core: done, errors");
        end
        $finish;
    end

endmodule

FILE: nearest_center_assigner_core.f
+incdir+rtl
rtl/ncac_pkg.sv
rtl/ncac_if.sv
rtl/ncac_front.sv
rtl/ncac_dist.sv
rtl/ncac_select.sv
rtl/ncac_out_fifo.sv
rtl/nearest_center_assigner_core.sv
test/tb_nearest_center_assigner_core.sv
